>>> hw/rtl/azimuth_sector_point_filter_core_defines.svh
// Assertion macros shared by the azimuth sector filter checkers.
`ifndef AZIMUTH_SECTOR_POINT_FILTER_CORE_DEFINES_SVH
`define AZIMUTH_SECTOR_POINT_FILTER_CORE_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define ASPF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aspf assertion failed");

// Check that a condition holds in the cycle after its trigger.
`define ASPF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aspf assertion failed");

`endif

>>> hw/rtl/aspf_pkg.sv
// Package with widths, register indexes and the arctangent table of the sector filter.
`timescale 1ns / 1ps

package aspf_pkg;

	localparam int COORD_W     = 32;
	localparam int INTEN_W     = 16;
	localparam int ANGLE_W     = 17;
	localparam int CFG_INDEX_W = 2;
	localparam int CORDIC_STEPS = 22;
	localparam int PRE_SCALE   = 20;
	localparam int XY_W        = 56;
	localparam int ACC_W       = 27;

	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_ANGLE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ANGLE = 2'd1;

	localparam logic signed [ANGLE_W-1:0] PI_BAM       = 17'sd32768;
	localparam logic signed [ANGLE_W-1:0] HALF_PI_BAM  = 17'sd16384;
	localparam logic signed [ANGLE_W-1:0] MIN_RESET    = -17'sd24576;
	localparam logic signed [ANGLE_W-1:0] MAX_RESET    = 17'sd24576;
	localparam logic signed [ACC_W-1:0]   HALF_PI_ACC  = 27'sd8388608;

	// Arctangent of 2^-idx, pi = 2^24.
	function automatic logic signed [ACC_W-1:0] atan_step(input int unsigned idx);
		logic signed [ACC_W-1:0] v;
		case (idx)
			0:  v = ACC_W'(4194304);
			1:  v = ACC_W'(2476042);
			2:  v = ACC_W'(1308273);
			3:  v = ACC_W'(664100);
			4:  v = ACC_W'(333339);
			5:  v = ACC_W'(166832);
			6:  v = ACC_W'(83436);
			7:  v = ACC_W'(41721);
			8:  v = ACC_W'(20861);
			9:  v = ACC_W'(10430);
			10: v = ACC_W'(5215);
			11: v = ACC_W'(2608);
			12: v = ACC_W'(1304);
			13: v = ACC_W'(652);
			14: v = ACC_W'(326);
			15: v = ACC_W'(163);
			16: v = ACC_W'(81);
			17: v = ACC_W'(41);
			18: v = ACC_W'(20);
			19: v = ACC_W'(10);
			20: v = ACC_W'(5);
			21: v = ACC_W'(3);
			default: v = '0;
		endcase
		return v;
	endfunction

	// Point data that rides alongside the rotation stages.
	typedef struct packed {
		logic [COORD_W-1:0]        px;
		logic [COORD_W-1:0]        py;
		logic [COORD_W-1:0]        pz;
		logic [INTEN_W-1:0]        inten;
		logic                      last;
		logic                      special;
		logic signed [ANGLE_W-1:0] spec_ang;
	} side_t;

	// Result item held in the output register.
	typedef struct packed {
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [COORD_W-1:0] pz;
		logic [INTEN_W-1:0] inten;
		logic               keep;
		logic               last;
	} res_t;

endpackage

>>> hw/rtl/azimuth_sector_point_filter_core.sv
// Top level of the azimuth sector point filter: pipeline, sector test and output register.
`timescale 1ns / 1ps

// Usage
//   Input channel in_valid/in_ready carries one lidar point per item: pos_x, pos_y,
//   pos_z (signed Q16.16), intensity and cloud_end.
//   Output channel out_valid/out_ready carries one result item per kept point, or a
//   bare end marker (point_valid 0, zeroed coordinates) when the last point of a
//   cloud is dropped. Dropped points that do not close a cloud produce no item.
//   Configuration channel cfg_valid/cfg_ready writes min_angle (index 0) or
//   max_angle (index 1); cfg_ready is always high and a write takes effect at once.
//   Written values saturate to plus or minus pi (32768).
// Timing
//   From acceptance to the result register an item passes the quadrant folding
//   register, 22 CORDIC vectoring stages (one step each), and the register of
//   rounding, sector test and output.
//   Throughput is one item per cycle while out_ready stays high.
// Reset and stalls
//   Reset empties every stage and restores the angle bounds to -135 and +135 deg.
//   When the receiver stalls with a result waiting, the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated. An empty output register never
//   holds the pipeline.
module azimuth_sector_point_filter_core (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic signed [aspf_pkg::COORD_W-1:0]       pos_x,
	input  logic signed [aspf_pkg::COORD_W-1:0]       pos_y,
	input  logic signed [aspf_pkg::COORD_W-1:0]       pos_z,
	input  logic        [aspf_pkg::INTEN_W-1:0]       intensity,
	input  logic                                      cloud_end,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [aspf_pkg::COORD_W-1:0]       out_x,
	output logic signed [aspf_pkg::COORD_W-1:0]       out_y,
	output logic signed [aspf_pkg::COORD_W-1:0]       out_z,
	output logic        [aspf_pkg::INTEN_W-1:0]       out_intensity,
	output logic                                      point_valid,
	output logic                                      out_cloud_end,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic        [aspf_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic signed [aspf_pkg::ANGLE_W-1:0]       cfg_data
);

	localparam int STEPS = aspf_pkg::CORDIC_STEPS;
	localparam int XY_W  = aspf_pkg::XY_W;
	localparam int ACC_W = aspf_pkg::ACC_W;
	localparam int CW    = aspf_pkg::COORD_W;
	localparam int AW    = aspf_pkg::ANGLE_W;
	localparam int FOLD_W = CW + 1;
	localparam int PAD_W = XY_W - FOLD_W - aspf_pkg::PRE_SCALE;
	localparam int RND_W = ACC_W - 9;

	// Configuration registers
	logic signed [AW-1:0] min_angle_q;
	logic signed [AW-1:0] max_angle_q;
	logic signed [AW-1:0] cfg_sat;

	// Pipeline control
	logic advance;

	// Stage 1: quadrant fold and pre-scale
	logic signed [FOLD_W-1:0] fx;
	logic signed [FOLD_W-1:0] fy;
	logic signed [FOLD_W-1:0] rx;
	logic signed [FOLD_W-1:0] ry;
	logic signed [ACC_W-1:0]  racc;
	logic                     spec;
	logic signed [AW-1:0]     spec_ang;

	logic                     valid_s1;
	logic signed [XY_W-1:0]   x_s1;
	logic signed [XY_W-1:0]   y_s1;
	logic signed [ACC_W-1:0]  acc_s1;
	aspf_pkg::side_t          side_s1;

	// CORDIC stages, entry k holds the result of step k
	logic                     valid_sc [STEPS];
	aspf_pkg::side_t          side_sc  [STEPS];
	logic signed [XY_W-1:0]   x_sc     [STEPS];
	logic signed [XY_W-1:0]   y_sc     [STEPS];
	logic signed [ACC_W-1:0]  acc_sc   [STEPS];

	// Final stage: rounding, sector test, output register
	logic signed [ACC_W-1:0]  rnd;
	logic signed [RND_W-1:0]  ang_wide;
	logic signed [AW-1:0]     ang_sat;
	logic signed [AW-1:0]     angle;
	logic                     keep;
	logic                     emit;
	logic                     valid_s24;
	aspf_pkg::res_t           res_s24;

	// Hold everything while a result waits; otherwise shift every cycle.
	assign advance  = !valid_s24 || out_ready;
	assign in_ready = advance;
	assign cfg_ready = 1'b1;

	// Saturate written angles to plus or minus pi.
	always_comb begin
		if (cfg_data > aspf_pkg::PI_BAM) begin
			cfg_sat = aspf_pkg::PI_BAM;
		end else if (cfg_data < -aspf_pkg::PI_BAM) begin
			cfg_sat = -aspf_pkg::PI_BAM;
		end else begin
			cfg_sat = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_angle_q <= aspf_pkg::MIN_RESET;
			max_angle_q <= aspf_pkg::MAX_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				aspf_pkg::CFG_MIN_ANGLE: min_angle_q <= cfg_sat;
				aspf_pkg::CFG_MAX_ANGLE: max_angle_q <= cfg_sat;
				default: ;
			endcase
		end
	end

	// Fold the point into the right half plane. Points on an axis take their
	// angle from a side value instead of the rotation result.
	always_comb begin
		fx = FOLD_W'(pos_x);
		fy = FOLD_W'(pos_y);
		spec     = 1'b0;
		spec_ang = '0;
		rx   = fx;
		ry   = fy;
		racc = '0;
		if (pos_y == '0) begin
			spec     = 1'b1;
			spec_ang = (pos_x < 0) ? aspf_pkg::PI_BAM : '0;
		end else if (pos_x == '0) begin
			spec     = 1'b1;
			spec_ang = (pos_y > 0) ? aspf_pkg::HALF_PI_BAM : -aspf_pkg::HALF_PI_BAM;
		end
		if (pos_x < 0) begin
			if (pos_y > 0) begin
				rx   = fy;
				ry   = -fx;
				racc = aspf_pkg::HALF_PI_ACC;
			end else begin
				rx   = -fy;
				ry   = fx;
				racc = -aspf_pkg::HALF_PI_ACC;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s1   <= {{PAD_W{rx[FOLD_W-1]}}, rx, {aspf_pkg::PRE_SCALE{1'b0}}};
			y_s1   <= {{PAD_W{ry[FOLD_W-1]}}, ry, {aspf_pkg::PRE_SCALE{1'b0}}};
			acc_s1 <= racc;
			side_s1.px       <= pos_x;
			side_s1.py       <= pos_y;
			side_s1.pz       <= pos_z;
			side_s1.inten    <= intensity;
			side_s1.last     <= cloud_end;
			side_s1.special  <= spec;
			side_s1.spec_ang <= spec_ang;
		end
	end

	// Rotation stages; valid bits and point data advance with them.
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		if (k == 0) begin : g_first
			aspf_cordic_stage #(.STEP(k)) u_stage (
				.clk(clk), .arst_n(arst_n), .en(advance),
				.x_in(x_s1), .y_in(y_s1), .acc_in(acc_s1),
				.x_out(x_sc[k]), .y_out(y_sc[k]), .acc_out(acc_sc[k])
			);
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_sc[k] <= 1'b0;
				end else if (advance) begin
					valid_sc[k] <= valid_s1;
				end
			end
			always_ff @(posedge clk) begin
				if (advance) begin
					side_sc[k] <= side_s1;
				end
			end
		end else begin : g_rest
			aspf_cordic_stage #(.STEP(k)) u_stage (
				.clk(clk), .arst_n(arst_n), .en(advance),
				.x_in(x_sc[k-1]), .y_in(y_sc[k-1]), .acc_in(acc_sc[k-1]),
				.x_out(x_sc[k]), .y_out(y_sc[k]), .acc_out(acc_sc[k])
			);
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_sc[k] <= 1'b0;
				end else if (advance) begin
					valid_sc[k] <= valid_sc[k-1];
				end
			end
			always_ff @(posedge clk) begin
				if (advance) begin
					side_sc[k] <= side_sc[k-1];
				end
			end
		end
	end

	// Round the accumulator to binary angle units: floor((acc + 256) / 512),
	// then clamp to plus or minus pi.
	assign rnd      = acc_sc[STEPS-1] + ACC_W'(256);
	assign ang_wide = rnd[ACC_W-1:9];

	always_comb begin
		if (ang_wide > RND_W'(aspf_pkg::PI_BAM)) begin
			ang_sat = aspf_pkg::PI_BAM;
		end else if (ang_wide < -RND_W'(aspf_pkg::PI_BAM)) begin
			ang_sat = -aspf_pkg::PI_BAM;
		end else begin
			ang_sat = ang_wide[AW-1:0];
		end
	end

	assign angle = side_sc[STEPS-1].special ? side_sc[STEPS-1].spec_ang : ang_sat;

	// Plain sector when min <= max, else the sector wraps through pi.
	always_comb begin
		if (min_angle_q <= max_angle_q) begin
			keep = (angle >= min_angle_q) && (angle <= max_angle_q);
		end else begin
			keep = (angle >= min_angle_q) || (angle <= max_angle_q);
		end
	end

	// Drop points outside the sector unless they close the cloud.
	assign emit = valid_sc[STEPS-1] && (keep || side_sc[STEPS-1].last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s24 <= 1'b0;
		end else if (advance) begin
			valid_s24 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s24.px    <= keep ? side_sc[STEPS-1].px : '0;
			res_s24.py    <= keep ? side_sc[STEPS-1].py : '0;
			res_s24.pz    <= keep ? side_sc[STEPS-1].pz : '0;
			res_s24.inten <= keep ? side_sc[STEPS-1].inten : '0;
			res_s24.keep  <= keep;
			res_s24.last  <= side_sc[STEPS-1].last;
		end
	end

	assign out_valid     = valid_s24;
	assign out_x         = res_s24.px;
	assign out_y         = res_s24.py;
	assign out_z         = res_s24.pz;
	assign out_intensity = res_s24.inten;
	assign point_valid   = res_s24.keep;
	assign out_cloud_end = res_s24.last;

endmodule

>>> hw/rtl/aspf_cordic_stage.sv
// One vectoring rotation step of the azimuth pipeline, registered.
`timescale 1ns / 1ps

module aspf_cordic_stage #(
	parameter int STEP = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic signed [aspf_pkg::XY_W-1:0]  x_in,
	input  logic signed [aspf_pkg::XY_W-1:0]  y_in,
	input  logic signed [aspf_pkg::ACC_W-1:0] acc_in,
	output logic signed [aspf_pkg::XY_W-1:0]  x_out,
	output logic signed [aspf_pkg::XY_W-1:0]  y_out,
	output logic signed [aspf_pkg::ACC_W-1:0] acc_out
);

	localparam logic signed [aspf_pkg::ACC_W-1:0] ATAN = aspf_pkg::atan_step(STEP);

	logic signed [aspf_pkg::XY_W-1:0]  xs;
	logic signed [aspf_pkg::XY_W-1:0]  ys;
	logic signed [aspf_pkg::XY_W-1:0]  x_nx;
	logic signed [aspf_pkg::XY_W-1:0]  y_nx;
	logic signed [aspf_pkg::ACC_W-1:0] acc_nx;

	assign xs = x_in >>> STEP;
	assign ys = y_in >>> STEP;

	// Rotate toward the x axis: sign of y picks the direction.
	always_comb begin
		if (y_in > 0) begin
			x_nx   = x_in + ys;
			y_nx   = y_in - xs;
			acc_nx = acc_in + ATAN;
		end else begin
			x_nx   = x_in - ys;
			y_nx   = y_in + xs;
			acc_nx = acc_in - ATAN;
		end
	end

	// Clear on reset; advance only when the pipeline moves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_out   <= '0;
			y_out   <= '0;
			acc_out <= '0;
		end else if (en) begin
			x_out   <= x_nx;
			y_out   <= y_nx;
			acc_out <= acc_nx;
		end
	end

endmodule

>>> hw/rtl/aspf_checker.sv
// Port-level checker for the azimuth sector filter and its bind.
`timescale 1ns / 1ps
`include "azimuth_sector_point_filter_core_defines.svh"

module aspf_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_ready,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic signed [aspf_pkg::COORD_W-1:0]     out_x,
	input logic signed [aspf_pkg::COORD_W-1:0]     out_y,
	input logic signed [aspf_pkg::COORD_W-1:0]     out_z,
	input logic        [aspf_pkg::INTEN_W-1:0]     out_intensity,
	input logic                                    point_valid,
	input logic                                    out_cloud_end
);

	// A waiting result is not withdrawn.
	`ASPF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

	// The pipeline takes input exactly when the output register can move.
	`ASPF_ASSERT_NOW(a_in_ready, 1'b1, in_ready == (!out_valid || out_ready))

	// A bare marker only ever closes a cloud.
	`ASPF_ASSERT_NOW(a_marker_end, out_valid && !point_valid, out_cloud_end)

	// A bare marker carries zeroed point data.
	`ASPF_ASSERT_NOW(a_marker_zero, out_valid && !point_valid,
		out_x == '0 && out_y == '0 && out_z == '0 && out_intensity == '0)

endmodule

bind azimuth_sector_point_filter_core aspf_checker u_aspf_checker (.*);

>>> dv/azimuth_sector_point_filter_core_test.sv
// Self-checking testbench for the azimuth sector point filter core.
`timescale 1ns / 1ps

module azimuth_sector_point_filter_core_test;

	localparam int COORD_W     = aspf_pkg::COORD_W;
	localparam int INTEN_W     = aspf_pkg::INTEN_W;
	localparam int ANGLE_W     = aspf_pkg::ANGLE_W;
	localparam int CFG_INDEX_W = aspf_pkg::CFG_INDEX_W;

	// Pipeline depth from acceptance to the result register.
	localparam int FILL_CYCLES = 24;
	// Angle units: a half turn is 32768, the CORDIC accumulator uses 2^24.
	localparam int HALF_TURN = 32768;
	localparam int QUARTER_TURN = 16384;
	localparam longint QUARTER_TURN_ACC = 64'sd8388608;
	localparam int RESET_LOWER = -24576;
	localparam int RESET_UPPER = 24576;
	// Register indexes with no register behind them; writes there must change nothing.
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;
	localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
	localparam logic [COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;

	// Arctangent of 2^-i with pi = 2^24.
	localparam longint ARCTAN_STEP [0:21] = '{
		4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
		20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3
	};

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [INTEN_W-1:0] inten;
		logic               kept;
		logic               last;
	} filtered_pt_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;
	logic [INTEN_W-1:0] intensity;
	logic cloud_end;
	logic out_valid;
	logic out_ready;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic signed [COORD_W-1:0] out_z;
	logic [INTEN_W-1:0] out_intensity;
	logic point_valid;
	logic out_cloud_end;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic signed [ANGLE_W-1:0] cfg_data;

	// Sector bounds as the block should hold them, already saturated.
	int lower_bound = RESET_LOWER;
	int upper_bound = RESET_UPPER;
	// Results still owed by the block, oldest first.
	filtered_pt_t filtered_q[$];
	filtered_pt_t head;
	int errors = 0;

	azimuth_sector_point_filter_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.intensity(intensity),
		.cloud_end(cloud_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z),
		.out_intensity(out_intensity),
		.point_valid(point_valid),
		.out_cloud_end(out_cloud_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Azimuth of (x, y) as a binary angle: axis cases exact, everything else through
	// a quadrant fold and 22 vectoring steps on coordinates scaled by 2^20.
	function automatic int point_bearing(input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py);
		longint vx, vy, sx, sy, turn, tmp;
		int i;
		vx = px;
		vy = py;
		turn = 0;
		if (vy == 0)
			return (vx >= 0) ? 0 : HALF_TURN;
		if (vx == 0)
			return (vy > 0) ? QUARTER_TURN : -QUARTER_TURN;
		// Fold the left half plane into the right one by a quarter turn.
		if (vx < 0) begin
			tmp = vx;
			if (vy > 0) begin
				vx = vy;
				vy = -tmp;
				turn = QUARTER_TURN_ACC;
			end else begin
				vx = -vy;
				vy = tmp;
				turn = -QUARTER_TURN_ACC;
			end
		end
		vx = vx * 64'sd1048576;
		vy = vy * 64'sd1048576;
		for (i = 0; i < 22; i++) begin
			sx = vx >>> i;
			sy = vy >>> i;
			if (vy > 0) begin
				vx = vx + sy;
				vy = vy - sx;
				turn = turn + ARCTAN_STEP[i];
			end else begin
				vx = vx - sy;
				vy = vy + sx;
				turn = turn - ARCTAN_STEP[i];
			end
		end
		// Round to the nearest binary angle unit, ties upward.
		turn = (turn + 256) >>> 9;
		if (turn > HALF_TURN)
			turn = HALF_TURN;
		if (turn < -HALF_TURN)
			turn = -HALF_TURN;
		return int'(turn);
	endfunction

	// Plain range when the bounds are ordered, otherwise a sector wrapping through pi.
	function automatic bit in_sector(input int bearing);
		if (lower_bound <= upper_bound)
			return bearing >= lower_bound && bearing <= upper_bound;
		return bearing >= lower_bound || bearing <= upper_bound;
	endfunction

	function automatic int clamp_bound(input logic signed [ANGLE_W-1:0] raw);
		int v;
		v = raw;
		if (v > HALF_TURN)
			v = HALF_TURN;
		if (v < -HALF_TURN)
			v = -HALF_TURN;
		return v;
	endfunction

	// Most often no pause, some short ones, a few long ones.
	function automatic int pick_pause();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 0;
		if (roll < 80)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Coordinates that hit the axes, small integers (exact 45 degree bearings), the extremes,
	// values within plus or minus 65536, and the full 32-bit range.
	function automatic logic [COORD_W-1:0] random_coord();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			return $urandom;
		if (roll < 60)
			return COORD_W'(int'($urandom_range(0, 8)) - 4);
		if (roll < 70)
			return '0;
		if (roll < 80) begin
			case ($urandom_range(0, 3))
				0: return COORD_MIN;
				1: return COORD_MAX;
				2: return '1;
				default: return COORD_W'(1);
			endcase
		end
		return COORD_W'(int'($urandom_range(0, 131072)) - 65536);
	endfunction

	// Bounds on 4096 steps often land exactly on bearings of small-integer points.
	function automatic logic signed [ANGLE_W-1:0] random_bound();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return ANGLE_W'(int'($urandom_range(0, 16)) * 4096 - HALF_TURN);
		if (roll < 90)
			return ANGLE_W'(int'($urandom_range(0, 65536)) - HALF_TURN);
		return ANGLE_W'($urandom);
	endfunction

	task automatic compare_field(input string name, input logic [COORD_W-1:0] want,
			input logic [COORD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Offer one point after a random pause, hold it until accepted, then record
	// what the block owes for it under the bounds in force.
	task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [COORD_W-1:0] z, input logic [INTEN_W-1:0] inten,
			input logic last);
		int gap;
		filtered_pt_t owed;
		gap = pick_pause();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		intensity <= inten;
		cloud_end <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (in_sector(point_bearing(x, y))) begin
			owed = '{x, y, z, inten, 1'b1, last};
			filtered_q.insert(filtered_q.size(), owed);
		end else if (last) begin
			owed = '{'0, '0, '0, '0, 1'b0, 1'b1};
			filtered_q.insert(filtered_q.size(), owed);
		end
	endtask

	task automatic send_random_point();
		logic [COORD_W-1:0] x, y;
		x = random_coord();
		y = random_coord();
		// Sometimes put the point on a diagonal.
		case ($urandom_range(0, 19))
			0: y = x;
			1: y = -x;
			default: ;
		endcase
		send_point(x, y, $urandom, INTEN_W'($urandom), $urandom_range(0, 5) == 0);
	endtask

	// Stop sending and let every owed result and every dropped point drain out.
	task automatic settle();
		in_valid <= 1'b0;
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (FILL_CYCLES + 8) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic signed [ANGLE_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == aspf_pkg::CFG_MIN_ANGLE)
			lower_bound = clamp_bound(value);
		else if (idx == aspf_pkg::CFG_MAX_ANGLE)
			upper_bound = clamp_bound(value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drain, program both bounds, poke the unused indexes, then stream points.
	task automatic run_sector_phase(input logic signed [ANGLE_W-1:0] lo,
			input logic signed [ANGLE_W-1:0] hi, input int points);
		settle();
		write_register(aspf_pkg::CFG_MIN_ANGLE, lo);
		write_register(aspf_pkg::CFG_MAX_ANGLE, hi);
		write_register(CFG_SPARE_2, ANGLE_W'($urandom));
		write_register(CFG_SPARE_3, ANGLE_W'($urandom));
		repeat (points) send_random_point();
	endtask

	// Reset bounds (-135..+135 deg): axes, origin, exact boundary bearings,
	// coordinate extremes, and dropped or kept last points.
	task automatic test_default_sector();
		send_point('0, '0, COORD_MIN, '0, 1'b0);
		send_point(-32'sd5, '0, COORD_MAX, 16'hffff, 1'b0);
		send_point('0, 32'sd7, 32'h1234_5678, 16'h00ff, 1'b0);
		send_point('0, -32'sd7, '1, 16'hff00, 1'b0);
		send_point(32'sd1, 32'sd1, '0, 16'h5555, 1'b0);
		send_point(-32'sd1, 32'sd1, COORD_MIN, 16'haaaa, 1'b0);
		send_point(-32'sd1, -32'sd1, COORD_MAX, 16'h0001, 1'b1);
		send_point(-32'sd2, 32'sd1, '0, 16'h8000, 1'b0);
		send_point(COORD_MIN, '0, '1, 16'hffff, 1'b1);
		send_point(COORD_MIN, COORD_MIN, '0, '0, 1'b0);
		send_point(COORD_MAX, COORD_MAX, COORD_MIN, 16'hffff, 1'b0);
		send_point(COORD_MAX, '0, COORD_MAX, '0, 1'b1);
		send_point('0, COORD_MIN, '1, 16'h7fff, 1'b0);
		send_point(COORD_MIN, 32'sd1, 32'h0000_0001, 16'h1234, 1'b1);
		send_point(COORD_MIN, -32'sd1, '0, 16'hfedc, 1'b0);
		send_point(32'sd1, COORD_MAX, 32'hdead_beef, 16'h4321, 1'b0);
		send_point(COORD_MIN, COORD_MAX, '0, '0, 1'b1);
		send_point(32'sd1, COORD_MIN, COORD_MIN, 16'hffff, 1'b1);
	endtask

	// Bound extremes, saturating writes, equal bounds and near-full wraps.
	task automatic test_register_extremes();
		run_sector_phase(-17'sd32768, 17'sd32768, 20);
		run_sector_phase(17'sd32768, -17'sd32768, 20);
		run_sector_phase(17'sh1_0000, 17'sd65535, 20);
		run_sector_phase(17'sd32769, -17'sd32769, 20);
		run_sector_phase('0, '0, 20);
		run_sector_phase(17'sd16384, -17'sd16384, 20);
		run_sector_phase(17'sd8192, 17'sd8191, 20);
	endtask

	task automatic test_random_sector_sweep();
		repeat (11) run_sector_phase(random_bound(), random_bound(), 125);
	endtask

	// Receiver: ready runs of random length, random stalls between them, and now
	// and then a long stretch with no stall at all.
	initial begin : receiver
		int run_len, hold_len;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
				: $urandom_range(1, 8);
			hold_len = pick_pause();
			out_ready <= 1'b1;
			repeat (run_len) @(posedge clk);
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
			end
		end
	end

	// Match each accepted result item against the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (filtered_q.size() == 0) begin
				$display("%0t: unexpected result item, expected none actual x=%h y=%h kept=%b",
					$time, out_x, out_y, point_valid);
				errors++;
			end else begin
				head = filtered_q.pop_front();
				compare_field("out_x", head.x, out_x);
				compare_field("out_y", head.y, out_y);
				compare_field("out_z", head.z, out_z);
				compare_field("out_intensity", COORD_W'(head.inten), COORD_W'(out_intensity));
				compare_field("point_valid", COORD_W'(head.kept), COORD_W'(point_valid));
				compare_field("out_cloud_end", COORD_W'(head.last), COORD_W'(out_cloud_end));
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		pos_x <= '0;
		pos_y <= '0;
		pos_z <= '0;
		intensity <= '0;
		cloud_end <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= aspf_pkg::CFG_MIN_ANGLE;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_sector();
		test_register_extremes();
		test_random_sector_sweep();
		settle();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Hang guard, far beyond the slowest legal run.
	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> azimuth_sector_point_filter_core.f
+incdir+hw/rtl
hw/rtl/aspf_pkg.sv
hw/rtl/aspf_cordic_stage.sv
hw/rtl/azimuth_sector_point_filter_core.sv
hw/rtl/aspf_checker.sv
dv/azimuth_sector_point_filter_core_test.sv
